FILE: rtl/s20x_pkg.sv
// Shared types and constants for the Salsa20 XOR core.
// Holds the quarter-round index table and step rotation amounts; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s20x_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned NWORDS = 16;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;

    // Word positions (a, b, c, d) of the eight quarter rounds of one double round:
    // four column quarters, then four row quarters.
    function automatic t_pos qidx(input logic [2:0] q, input logic [1:0] j);
        logic [15:0] row;
        begin
            row = 16'h0000;
            unique case (q)
                3'd0: row = {4'd12, 4'd8,  4'd4,  4'd0};
                3'd1: row = {4'd1,  4'd13, 4'd9,  4'd5};
                3'd2: row = {4'd6,  4'd2,  4'd14, 4'd10};
                3'd3: row = {4'd11, 4'd7,  4'd3,  4'd15};
                3'd4: row = {4'd3,  4'd2,  4'd1,  4'd0};
                3'd5: row = {4'd4,  4'd7,  4'd6,  4'd5};
                3'd6: row = {4'd9,  4'd8,  4'd11, 4'd10};
                3'd7: row = {4'd14, 4'd13, 4'd12, 4'd15};
                default: row = 16'h0000;
            endcase
            qidx = row[j*4 +: 4];
        end
    endfunction

    function automatic t_word rotl(input t_word v, input logic [1:0] step);
        begin
            rotl = v;
            unique case (step)
                2'd0: rotl = {v[24:0], v[31:25]};
                2'd1: rotl = {v[22:0], v[31:23]};
                2'd2: rotl = {v[18:0], v[31:19]};
                2'd3: rotl = {v[13:0], v[31:14]};
                default: rotl = v;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/salsa20_8_xor_core_unit.sv
// Salsa20 XOR core top level: load, round sequencer and result output.
// Depends on s20x_pkg and s20x_ram.
`timescale 1ns / 1ps
`default_nettype none

// One beat loads one word pair; the block stores B ^ Bx at word_pos and takes a
// load beat every cycle while idle. A beat at position 15 starts the core: one
// shared add-rotate-xor unit works through the quarter rounds; for each quarter
// RD0 to RD2 fetch its four words over two RAM read ports, then come 4 steps and
// 4 write-backs on the single write port. Then the 16 result words leave in
// order, each read (ORD), captured (OCAP) and held until the sink takes it
// (OWAIT) before the next is read, the sixteenth with tlast set. No load is taken
// from the position-15 beat until the last result beat has gone.
module salsa20_8_xor_core_unit
    import s20x_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUNDS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [3:0] word_pos, [35:4] b_word, [67:36] bx_word, [71:68] zero
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [3:0] out_pos, [35:4] out_word, [39:36] zero
    output logic      [39:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    localparam int unsigned DR_W = $clog2(DOUBLE_ROUNDS + 1);
    localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_STEP  = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_ORD   = 4'd6;
    localparam logic [3:0] S_OCAP  = 4'd7;
    localparam logic [3:0] S_OWAIT = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [2:0]      r_q;
    logic [DR_W-1:0] r_dr;
    logic [1:0]      r_k;
    t_pos            r_opos;
    t_word           r_qa, r_qb, r_qc, r_qd;
    logic            r_out_valid;
    t_pos            r_out_pos;
    t_word           r_out_word;
    logic            r_out_last;

    logic  in_fire, out_fire, from_x;
    t_pos  in_pos;
    t_word in_xor;
    t_pos  rd_a, rd_b, wr_addr;
    t_word x_rd_a, x_rd_b, w_rd_a, w_rd_b, src_a, src_b;
    t_word op_x, op_y, op_t, step_res, wb_data;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign in_pos   = i_s_axis_tdata[3:0];
    assign in_xor   = i_s_axis_tdata[35:4] ^ i_s_axis_tdata[67:36];

    // first column round reads straight from the stored input words
    assign from_x = (r_dr == '0) && !r_q[2];
    assign src_a  = from_x ? x_rd_a : w_rd_a;
    assign src_b  = from_x ? x_rd_b : w_rd_b;

    always_comb begin
        rd_a = qidx(r_q, 2'd0);
        rd_b = qidx(r_q, 2'd1);
        unique case (r_state)
            S_RD1: begin
                rd_a = qidx(r_q, 2'd2);
                rd_b = qidx(r_q, 2'd3);
            end
            S_ORD: begin
                rd_a = r_opos;
                rd_b = r_opos;
            end
            default: begin
                rd_a = qidx(r_q, 2'd0);
                rd_b = qidx(r_q, 2'd1);
            end
        endcase
    end

    assign wr_addr = qidx(r_q, r_k);

    // shared add-rotate-xor unit
    always_comb begin
        op_x = r_qa;
        op_y = r_qd;
        op_t = r_qb;
        unique case (r_k)
            2'd0: begin op_x = r_qa; op_y = r_qd; op_t = r_qb; end
            2'd1: begin op_x = r_qb; op_y = r_qa; op_t = r_qc; end
            2'd2: begin op_x = r_qc; op_y = r_qb; op_t = r_qd; end
            2'd3: begin op_x = r_qd; op_y = r_qc; op_t = r_qa; end
            default: begin op_x = r_qa; op_y = r_qd; op_t = r_qb; end
        endcase
        step_res = op_t ^ rotl(op_x + op_y, r_k);
    end

    always_comb begin
        unique case (r_k)
            2'd0:    wb_data = r_qa;
            2'd1:    wb_data = r_qb;
            2'd2:    wb_data = r_qc;
            2'd3:    wb_data = r_qd;
            default: wb_data = r_qa;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire && in_pos == 4'd15) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_STEP;
            S_STEP:  if (r_k == 2'd3) n_state = S_WB;
            S_WB: begin
                if (r_k == 2'd3) begin
                    n_state = (r_q == 3'd7 && r_dr == DR_LAST) ? S_ORD : S_RD0;
                end
            end
            S_ORD:   n_state = S_OCAP;
            S_OCAP:  n_state = S_OWAIT;
            S_OWAIT: if (out_fire) n_state = r_out_last ? S_IDLE : S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    s20x_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_xram (
        .i_clk     (i_clk),
        .i_we      (in_fire),
        .i_waddr   (in_pos),
        .i_wdata   (in_xor),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (x_rd_a),
        .o_rdata_b (x_rd_b)
    );

    s20x_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_wram (
        .i_clk     (i_clk),
        .i_we      (r_state == S_WB),
        .i_waddr   (wr_addr),
        .i_wdata   (wb_data),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q         <= '0;
            r_dr        <= '0;
            r_k         <= '0;
            r_opos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_q  <= '0;
                    r_dr <= '0;
                    r_k  <= '0;
                end
                S_STEP: r_k <= r_k + 2'd1;
                S_WB: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_q <= r_q + 3'd1;
                        if (r_q == 3'd7) begin
                            r_dr   <= r_dr + DR_W'(1);
                            r_opos <= '0;
                        end
                    end
                end
                S_OCAP: r_out_valid <= 1'b1;
                S_OWAIT: begin
                    if (out_fire) begin
                        r_out_valid <= 1'b0;
                        r_opos      <= r_opos + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // quarter words and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RD1: begin
                r_qa <= src_a;
                r_qb <= src_b;
            end
            S_RD2: begin
                r_qc <= src_a;
                r_qd <= src_b;
            end
            S_STEP: begin
                unique case (r_k)
                    2'd0:    r_qb <= step_res;
                    2'd1:    r_qc <= step_res;
                    2'd2:    r_qd <= step_res;
                    2'd3:    r_qa <= step_res;
                    default: r_qa <= step_res;
                endcase
            end
            S_OCAP: begin
                r_out_pos  <= r_opos;
                r_out_word <= x_rd_a + w_rd_a;
                r_out_last <= (r_opos == 4'd15);
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_word, r_out_pos};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/s20x_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module s20x_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire
